// File: rtl/core/dtm_pkg.sv
// Package for the detection-to-truth matcher: field widths, codes, FSM states.
// No dependencies; every other file in rtl/core refers to it by scoped names.
`default_nettype none

package dtm_pkg;

   localparam int FUNC_W = 2;
   localparam int IMG_W  = 16;
   localparam int THR_W  = 16;
   localparam int TOT_W  = 16;
   localparam int SLOT_W = 6;
   localparam int MISS_W = 7;

   localparam logic [THR_W-1:0] THR_RESET = 16'd32768;
   localparam logic [TOT_W-1:0] TOT_MAX   = 16'hFFFF;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD        = 2'd0,
      FUNC_DETECT      = 2'd1,
      FUNC_CLEAR_MATCH = 2'd2,
      FUNC_CLEAR_TABLE = 2'd3
   } dtm_func_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_CLEAR,
      S_DAREA,
      S_SCAN,
      S_CROSS_A,
      S_CROSS_B,
      S_CMP,
      S_THR,
      S_DECIDE
   } dtm_state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_BOX_AREA,
      MUL_INTER,
      MUL_CROSS_A,
      MUL_CROSS_B,
      MUL_THRESH
   } dtm_mul_op_type;

   typedef struct packed {
      logic tbl_we;
      logic flag_we;
      logic flag_wdata;
   } dtm_store_ctl_type;

endpackage

`default_nettype wire

// File: rtl/core/dtm_if.sv
// Channel interfaces of the matcher: request, response and CSR write.
// Depends on dtm_pkg for field widths.
`default_nettype none

interface dtm_req_if #(parameter int COORD_BITS = 12);
   logic                        valid;
   logic                        ready;
   logic [dtm_pkg::FUNC_W-1:0]  func;
   logic [dtm_pkg::IMG_W-1:0]   image_id;
   logic [COORD_BITS-1:0]       x_min;
   logic [COORD_BITS-1:0]       y_min;
   logic [COORD_BITS-1:0]       x_max;
   logic [COORD_BITS-1:0]       y_max;
   modport source (output valid, func, image_id, x_min, y_min, x_max, y_max, input ready);
   modport sink   (input valid, func, image_id, x_min, y_min, x_max, y_max, output ready);
endinterface

interface dtm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        is_true_positive;
   logic [dtm_pkg::SLOT_W-1:0]  match_slot;
   logic [dtm_pkg::TOT_W-1:0]   tp_total;
   logic [dtm_pkg::TOT_W-1:0]   fp_total;
   logic [dtm_pkg::MISS_W-1:0]  missed_total;
   modport source (output valid, is_true_positive, match_slot, tp_total, fp_total,
                   missed_total, input ready);
   modport sink   (input valid, is_true_positive, match_slot, tp_total, fp_total,
                   missed_total, output ready);
endinterface

interface dtm_csr_if;
   logic                        valid;
   logic                        ready;
   logic [dtm_pkg::THR_W-1:0]   iou_threshold;
   modport source (output valid, iou_threshold, input ready);
   modport sink   (input valid, iou_threshold, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dtm_store.sv
// Truth table and matched-flag memories, one write and one registered read each.
// Depends on dtm_pkg for the write control struct.
`default_nettype none

module dtm_store #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6,
   parameter int ENT_W = 89
) (
   input  logic                       clock,
   input  dtm_pkg::dtm_store_ctl_type ctl,
   input  logic [IDX_W-1:0]           tbl_waddr,
   input  logic [ENT_W-1:0]           tbl_wdata,
   input  logic [IDX_W-1:0]           tbl_raddr,
   output logic [ENT_W-1:0]           tbl_rdata,
   input  logic [IDX_W-1:0]           flag_waddr,
   input  logic [IDX_W-1:0]           flag_raddr,
   output logic                       flag_rdata
);

   logic [ENT_W-1:0] tbl_mem [DEPTH];
   logic             flag_mem [DEPTH];
   logic [ENT_W-1:0] tbl_rd_ff;
   logic             flag_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      tbl_rd_ff <= tbl_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.flag_we) begin
         flag_mem[flag_waddr] <= ctl.flag_wdata;
      end
      flag_rd_ff <= flag_mem[flag_raddr];
   end

   assign tbl_rdata  = tbl_rd_ff;
   assign flag_rdata = flag_rd_ff;

endmodule

`default_nettype wire

// File: rtl/core/dtm_mul_unit.sv
// Shared multiplier of the matcher: picks one operand pair per cycle by op code.
// Depends on dtm_pkg for the op codes and the threshold width.
`default_nettype none

module dtm_mul_unit #(
   parameter int SIDE_W = 13,
   parameter int AREA_W = 25
) (
   input  dtm_pkg::dtm_mul_op_type   op,
   input  logic [SIDE_W-1:0]         box_w,
   input  logic [SIDE_W-1:0]         box_h,
   input  logic [SIDE_W-1:0]         ovl_w,
   input  logic [SIDE_W-1:0]         ovl_h,
   input  logic [AREA_W-1:0]         inter,
   input  logic [AREA_W-1:0]         uni,
   input  logic [AREA_W-1:0]         best_inter,
   input  logic [AREA_W-1:0]         best_uni,
   input  logic [dtm_pkg::THR_W-1:0] thr,
   output logic [2*AREA_W-1:0]       prod
);

   localparam int PROD_W = 2 * AREA_W;

   logic [AREA_W-1:0] opa;
   logic [AREA_W-1:0] opb;

   always_comb begin
      case (op)
         dtm_pkg::MUL_BOX_AREA: begin
            opa = AREA_W'(box_w);
            opb = AREA_W'(box_h);
         end
         dtm_pkg::MUL_INTER: begin
            opa = AREA_W'(ovl_w);
            opb = AREA_W'(ovl_h);
         end
         // candidate inter times best union
         dtm_pkg::MUL_CROSS_A: begin
            opa = inter;
            opb = best_uni;
         end
         // best inter times candidate union
         dtm_pkg::MUL_CROSS_B: begin
            opa = best_inter;
            opb = uni;
         end
         dtm_pkg::MUL_THRESH: begin
            opa = AREA_W'(thr);
            opb = best_uni;
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign prod = PROD_W'(opa) * PROD_W'(opb);

endmodule

`default_nettype wire

// File: rtl/core/detection_to_truth_matcher.sv
// Sequence: load writes one slot, clear matches walks the flags of all loaded entries,
// clear table resets the count; a detection computes its area, scans every entry, with
// two cross products and a compare per entry of its image, then tests the threshold.
// One item at a time on the shared multiplier; a result waits for a free response slot.
// Reset (synchronous, active high) empties the table, zeroes counters and threshold
// goes to 0.5; no clearing pass, the block is ready in the cycle after reset.
`default_nettype none

module detection_to_truth_matcher #(
   parameter int TRUTH_DEPTH = 64,
   parameter int COORD_BITS  = 12
) (
   input  logic       clock,
   input  logic       reset,
   dtm_req_if.sink    req_port,
   dtm_rsp_if.source  rsp_port,
   dtm_csr_if.sink    csr_port
);

   // Widths. A side is max - min + 1, so it needs one more bit than a coordinate.
   localparam int IDX_W  = (TRUTH_DEPTH > 1) ? $clog2(TRUTH_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TRUTH_DEPTH + 1);
   localparam int SIDE_W = COORD_BITS + 1;
   localparam int AREA_W = 2 * COORD_BITS + 1;
   localparam int PROD_W = 2 * AREA_W;
   localparam int IMG_W  = dtm_pkg::IMG_W;
   localparam int THR_W  = dtm_pkg::THR_W;
   localparam int TOT_W  = dtm_pkg::TOT_W;

   // Table entry layout: {image, x0, y0, x1, y1, area}. Area is computed at load.
   localparam int OFS_Y1  = AREA_W;
   localparam int OFS_X1  = AREA_W + COORD_BITS;
   localparam int OFS_Y0  = AREA_W + 2 * COORD_BITS;
   localparam int OFS_X0  = AREA_W + 3 * COORD_BITS;
   localparam int OFS_IMG = AREA_W + 4 * COORD_BITS;
   localparam int ENT_W   = OFS_IMG + IMG_W;

   function automatic logic [SIDE_W-1:0] side_len(input logic [COORD_BITS-1:0] lo,
                                                  input logic [COORD_BITS-1:0] hi);
      side_len = (hi >= lo) ? (SIDE_W'(hi) - SIDE_W'(lo) + SIDE_W'(1)) : '0;
   endfunction

   // ---------------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------------
   dtm_pkg::dtm_state_type state_ff, state_in;

   // current item
   logic [IMG_W-1:0]      img_ff;
   logic [COORD_BITS-1:0] x0_ff, y0_ff, x1_ff, y1_ff;

   logic [CNT_W-1:0] count_ff, count_in;     // truth entries loaded
   logic [CNT_W-1:0] k_ff, k_in;             // scan / clear pointer
   logic [THR_W-1:0] thr_ff, thr_in;
   logic [TOT_W-1:0] tp_ff, tp_in, fp_ff, fp_in;

   // scan datapath
   logic [AREA_W-1:0] ad_ff, ad_in;          // detection area
   logic [AREA_W-1:0] inter_ff, inter_in;    // candidate intersection
   logic [AREA_W-1:0] uni_ff, uni_in;        // candidate union
   logic [AREA_W-1:0] bi_ff, bi_in;          // best intersection so far
   logic [AREA_W-1:0] bu_ff, bu_in;          // best union so far
   logic [PROD_W-1:0] pa_ff, pa_in;
   logic [PROD_W-1:0] pb_ff, pb_in;
   logic [IDX_W-1:0]  best_ff, best_in;
   logic              found_ff, found_in;

   // response register
   logic                       rv_ff, rv_in;
   logic                       rtp_ff, rtp_in;
   logic [dtm_pkg::SLOT_W-1:0] rslot_ff, rslot_in;
   logic [TOT_W-1:0]           rtpt_ff, rtpt_in;
   logic [TOT_W-1:0]           rfpt_ff, rfpt_in;
   logic [dtm_pkg::MISS_W-1:0] rmiss_ff, rmiss_in;

   // ---------------------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------------------
   logic req_ready;
   logic req_xfer;
   logic csr_xfer;
   logic out_free;
   dtm_pkg::dtm_func_type req_func;

   assign req_ready      = (state_ff == dtm_pkg::S_IDLE) && !reset;
   assign req_port.ready = req_ready;
   assign req_xfer       = req_port.valid && req_ready;
   assign req_func       = dtm_pkg::dtm_func_type'(req_port.func);

   // Threshold writes are taken any time; the host must make writes only while idle; the block does not enforce this.
   assign csr_port.ready = !reset;
   assign csr_xfer       = csr_port.valid && !reset;

   // The response slot can take a new result once the old one is gone.
   assign out_free = !rv_ff || rsp_port.ready;

   // ---------------------------------------------------------------------------
   // Table readout and box geometry
   // ---------------------------------------------------------------------------
   dtm_pkg::dtm_store_ctl_type st_ctl;
   dtm_pkg::dtm_mul_op_type    mul_op;
   logic [IDX_W-1:0]           flag_waddr;
   logic [ENT_W-1:0]           tbl_rdata;
   logic                       flag_rdata;
   logic [PROD_W-1:0]          prod;

   logic [IMG_W-1:0]      t_img;
   logic [COORD_BITS-1:0] t_x0, t_y0, t_x1, t_y1;
   logic [AREA_W-1:0]     t_area;
   logic [COORD_BITS-1:0] o_x0, o_y0, o_x1, o_y1;
   logic [SIDE_W-1:0]     det_w, det_h, ovl_w, ovl_h;

   assign t_img  = tbl_rdata[OFS_IMG +: IMG_W];
   assign t_x0   = tbl_rdata[OFS_X0 +: COORD_BITS];
   assign t_y0   = tbl_rdata[OFS_Y0 +: COORD_BITS];
   assign t_x1   = tbl_rdata[OFS_X1 +: COORD_BITS];
   assign t_y1   = tbl_rdata[OFS_Y1 +: COORD_BITS];
   assign t_area = tbl_rdata[AREA_W-1:0];

   // overlap rectangle: inner of the two left/top edges and of the two right/bottom edges
   assign o_x0 = (t_x0 > x0_ff) ? t_x0 : x0_ff;
   assign o_y0 = (t_y0 > y0_ff) ? t_y0 : y0_ff;
   assign o_x1 = (t_x1 < x1_ff) ? t_x1 : x1_ff;
   assign o_y1 = (t_y1 < y1_ff) ? t_y1 : y1_ff;

   assign det_w = side_len(x0_ff, x1_ff);
   assign det_h = side_len(y0_ff, y1_ff);
   assign ovl_w = side_len(o_x0, o_x1);
   assign ovl_h = side_len(o_y0, o_y1);

   // ---------------------------------------------------------------------------
   // Decisions
   // ---------------------------------------------------------------------------
   logic [CNT_W-1:0] k_next;
   logic             k_last;
   logic             count_full;
   logic             img_hit;
   logic             better;
   logic             thr_hit;
   logic             tp_hit;
   logic [TOT_W-1:0] count_wide;
   logic [TOT_W-1:0] missed_wide;

   assign k_next     = k_ff + CNT_W'(1);
   assign k_last     = (k_next == count_ff);
   assign count_full = (count_ff == CNT_W'(TRUTH_DEPTH));
   assign img_hit    = (t_img == img_ff);

   // inter_k / uni_k > bi / bu  <=>  inter_k * bu > bi * uni_k; first hit always wins
   assign better  = !found_ff || (pa_ff > pb_ff);
   // bi / bu > thr / 2^16  <=>  bi * 2^16 > thr * bu
   assign thr_hit = PROD_W'({bi_ff, {THR_W{1'b0}}}) > pa_ff;
   assign tp_hit  = found_ff && thr_hit && !flag_rdata;

   assign count_wide  = TOT_W'(count_ff);
   assign missed_wide = (count_wide > tp_in) ? (count_wide - tp_in) : '0;

   // ---------------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtm_pkg::S_IDLE: begin
            if (req_xfer) begin
               case (req_func)
                  dtm_pkg::FUNC_LOAD: begin
                     if (!count_full) begin
                        state_in = dtm_pkg::S_LOAD;
                     end
                  end
                  dtm_pkg::FUNC_DETECT: begin
                     state_in = dtm_pkg::S_DAREA;
                  end
                  dtm_pkg::FUNC_CLEAR_MATCH: begin
                     if (count_ff != '0) begin
                        state_in = dtm_pkg::S_CLEAR;
                     end
                  end
                  default: begin
                     state_in = dtm_pkg::S_IDLE;
                  end
               endcase
            end
         end
         dtm_pkg::S_LOAD: begin
            state_in = dtm_pkg::S_IDLE;
         end
         dtm_pkg::S_CLEAR: begin
            if (k_last) begin
               state_in = dtm_pkg::S_IDLE;
            end
         end
         dtm_pkg::S_DAREA: begin
            state_in = (count_ff == '0) ? dtm_pkg::S_THR : dtm_pkg::S_SCAN;
         end
         dtm_pkg::S_SCAN: begin
            if (img_hit) begin
               state_in = dtm_pkg::S_CROSS_A;
            end else if (k_last) begin
               state_in = dtm_pkg::S_THR;
            end
         end
         dtm_pkg::S_CROSS_A: begin
            state_in = dtm_pkg::S_CROSS_B;
         end
         dtm_pkg::S_CROSS_B: begin
            state_in = dtm_pkg::S_CMP;
         end
         dtm_pkg::S_CMP: begin
            state_in = k_last ? dtm_pkg::S_THR : dtm_pkg::S_SCAN;
         end
         dtm_pkg::S_THR: begin
            state_in = dtm_pkg::S_DECIDE;
         end
         dtm_pkg::S_DECIDE: begin
            if (out_free) begin
               state_in = dtm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dtm_pkg::S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Sequencer: outputs (multiplier op, memory writes)
   // ---------------------------------------------------------------------------
   always_comb begin
      mul_op     = dtm_pkg::MUL_NONE;
      st_ctl     = '0;
      flag_waddr = best_ff;
      case (state_ff)
         dtm_pkg::S_LOAD: begin
            // new slot: store box with its area, and clear its matched flag
            mul_op         = dtm_pkg::MUL_BOX_AREA;
            st_ctl.tbl_we  = 1'b1;
            st_ctl.flag_we = 1'b1;
            flag_waddr     = count_ff[IDX_W-1:0];
         end
         dtm_pkg::S_CLEAR: begin
            st_ctl.flag_we = 1'b1;
            flag_waddr     = k_ff[IDX_W-1:0];
         end
         dtm_pkg::S_DAREA: begin
            mul_op = dtm_pkg::MUL_BOX_AREA;
         end
         dtm_pkg::S_SCAN: begin
            mul_op = dtm_pkg::MUL_INTER;
         end
         dtm_pkg::S_CROSS_A: begin
            mul_op = dtm_pkg::MUL_CROSS_A;
         end
         dtm_pkg::S_CROSS_B: begin
            mul_op = dtm_pkg::MUL_CROSS_B;
         end
         dtm_pkg::S_THR: begin
            mul_op = dtm_pkg::MUL_THRESH;
         end
         dtm_pkg::S_DECIDE: begin
            st_ctl.flag_we    = out_free && tp_hit;
            st_ctl.flag_wdata = 1'b1;
         end
         default: begin
            mul_op = dtm_pkg::MUL_NONE;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Datapath next values
   // ---------------------------------------------------------------------------
   always_comb begin
      count_in = count_ff;
      k_in     = k_ff;
      thr_in   = csr_xfer ? csr_port.iou_threshold : thr_ff;
      tp_in    = tp_ff;
      fp_in    = fp_ff;
      ad_in    = ad_ff;
      inter_in = inter_ff;
      uni_in   = uni_ff;
      bi_in    = bi_ff;
      bu_in    = bu_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      best_in  = best_ff;
      found_in = found_ff;
      rv_in    = rsp_port.ready ? 1'b0 : rv_ff;
      rtp_in   = rtp_ff;
      rslot_in = rslot_ff;
      rtpt_in  = rtpt_ff;
      rfpt_in  = rfpt_ff;
      rmiss_in = rmiss_ff;

      case (state_ff)
         dtm_pkg::S_IDLE: begin
            if (req_xfer) begin
               k_in = '0;
               case (req_func)
                  dtm_pkg::FUNC_DETECT: begin
                     found_in = 1'b0;
                     best_in  = '0;
                     bi_in    = '0;
                     bu_in    = '0;
                  end
                  dtm_pkg::FUNC_CLEAR_MATCH: begin
                     tp_in = '0;
                     fp_in = '0;
                  end
                  dtm_pkg::FUNC_CLEAR_TABLE: begin
                     // stale flags above the count are cleared again on load
                     count_in = '0;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         dtm_pkg::S_LOAD: begin
            count_in = count_ff + CNT_W'(1);
         end
         dtm_pkg::S_CLEAR: begin
            k_in = k_next;
         end
         dtm_pkg::S_DAREA: begin
            ad_in = prod[AREA_W-1:0];
         end
         dtm_pkg::S_SCAN: begin
            if (img_hit) begin
               inter_in = prod[AREA_W-1:0];
            end else begin
               k_in = k_next;
            end
         end
         dtm_pkg::S_CROSS_A: begin
            pa_in  = prod;
            uni_in = AREA_W'({1'b0, t_area} + {1'b0, ad_ff} - {1'b0, inter_ff});
         end
         dtm_pkg::S_CROSS_B: begin
            pb_in = prod;
         end
         dtm_pkg::S_CMP: begin
            if (better) begin
               found_in = 1'b1;
               best_in  = k_ff[IDX_W-1:0];
               bi_in    = inter_ff;
               bu_in    = uni_ff;
            end
            k_in = k_next;
         end
         dtm_pkg::S_THR: begin
            pa_in = prod;
         end
         dtm_pkg::S_DECIDE: begin
            if (out_free) begin
               if (tp_hit) begin
                  tp_in = (tp_ff == dtm_pkg::TOT_MAX) ? tp_ff : tp_ff + TOT_W'(1);
               end else begin
                  fp_in = (fp_ff == dtm_pkg::TOT_MAX) ? fp_ff : fp_ff + TOT_W'(1);
               end
               rv_in    = 1'b1;
               rtp_in   = tp_hit;
               rslot_in = dtm_pkg::SLOT_W'(best_ff);
               rtpt_in  = tp_in;
               rfpt_in  = fp_in;
               rmiss_in = dtm_pkg::MISS_W'(missed_wide);
            end
         end
         default: begin
            k_in = k_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtm_pkg::S_IDLE;
         count_ff <= '0;
         thr_ff   <= dtm_pkg::THR_RESET;
         tp_ff    <= '0;
         fp_ff    <= '0;
         found_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         thr_ff   <= thr_in;
         tp_ff    <= tp_in;
         fp_ff    <= fp_in;
         found_ff <= found_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         img_ff <= req_port.image_id;
         x0_ff  <= req_port.x_min;
         y0_ff  <= req_port.y_min;
         x1_ff  <= req_port.x_max;
         y1_ff  <= req_port.y_max;
      end
      k_ff     <= k_in;
      ad_ff    <= ad_in;
      inter_ff <= inter_in;
      uni_ff   <= uni_in;
      bi_ff    <= bi_in;
      bu_ff    <= bu_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      best_ff  <= best_in;
      rtp_ff   <= rtp_in;
      rslot_ff <= rslot_in;
      rtpt_ff  <= rtpt_in;
      rfpt_ff  <= rfpt_in;
      rmiss_ff <= rmiss_in;
   end

   assign rsp_port.valid            = rv_ff;
   assign rsp_port.is_true_positive = rtp_ff;
   assign rsp_port.match_slot       = rslot_ff;
   assign rsp_port.tp_total         = rtpt_ff;
   assign rsp_port.fp_total         = rfpt_ff;
   assign rsp_port.missed_total     = rmiss_ff;

   // ---------------------------------------------------------------------------
   // Shared multiplier and memories
   // ---------------------------------------------------------------------------
   dtm_mul_unit #(
      .SIDE_W (SIDE_W),
      .AREA_W (AREA_W)
   ) u_mul (
      .op         (mul_op),
      .box_w      (det_w),
      .box_h      (det_h),
      .ovl_w      (ovl_w),
      .ovl_h      (ovl_h),
      .inter      (inter_ff),
      .uni        (uni_ff),
      .best_inter (bi_ff),
      .best_uni   (bu_ff),
      .thr        (thr_ff),
      .prod       (prod)
   );

   // read address follows the next pointer so the entry at k_ff is always on hand
   dtm_store #(
      .DEPTH (TRUTH_DEPTH),
      .IDX_W (IDX_W),
      .ENT_W (ENT_W)
   ) u_store (
      .clock      (clock),
      .ctl        (st_ctl),
      .tbl_waddr  (count_ff[IDX_W-1:0]),
      .tbl_wdata  ({img_ff, x0_ff, y0_ff, x1_ff, y1_ff, prod[AREA_W-1:0]}),
      .tbl_raddr  (k_in[IDX_W-1:0]),
      .tbl_rdata  (tbl_rdata),
      .flag_waddr (flag_waddr),
      .flag_raddr (best_ff),
      .flag_rdata (flag_rdata)
   );

endmodule

`default_nettype wire

// File: rtl/core/dtm_checker.sv
// Port-level assertions for the matcher and the bind that attaches them.
// Depends on dtm_pkg and on detection_to_truth_matcher.
`default_nettype none

module dtm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [dtm_pkg::FUNC_W-1:0]       req_func,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_is_tp,
   input logic [dtm_pkg::TOT_W-1:0]        rsp_tp_total,
   input logic [dtm_pkg::TOT_W-1:0]        rsp_fp_total
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tp_total) && $stable(rsp_fp_total))
      else $error("response changed while stalled");

   // a detection keeps the block busy for at least the next cycle
   a_detect_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == dtm_pkg::FUNC_DETECT |=> !req_ready)
      else $error("ready right after detection transfer");

   // the counter that the verdict bumped cannot be zero
   a_count_bumped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_tp ? (rsp_tp_total != '0) : (rsp_fp_total != '0)))
      else $error("result counter zero");

   // a new result is only produced while the block is busy
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while idle");

endmodule

bind detection_to_truth_matcher dtm_checker u_dtm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_port.valid),
   .req_ready    (req_port.ready),
   .req_func     (req_port.func),
   .rsp_valid    (rsp_port.valid),
   .rsp_ready    (rsp_port.ready),
   .rsp_is_tp    (rsp_port.is_true_positive),
   .rsp_tp_total (rsp_port.tp_total),
   .rsp_fp_total (rsp_port.fp_total)
);

`default_nettype wire
